/* design/artm_pkg.sv */
// ----------------------------------------------------------------------------
// artm_pkg: shared definitions for the application rate threshold monitor
// Sizes, register indexes, event codes and the sequencer state type.
// ----------------------------------------------------------------------------
package artm_pkg;

    localparam int NUM_APPS = 512;
    localparam int IDX_W    = $clog2(NUM_APPS);

    localparam int APP_W    = 9;
    localparam int TOTAL_W  = 64;
    localparam int MS_W     = 16;
    localparam int THR_W    = 48;
    localparam int HYST_W   = 9;
    localparam int MININT_W = 10;
    localparam int KIND_W   = 2;

    // Shared multiplier and accumulator sizes.
    localparam int MUL_A_W  = 32;
    localparam int MUL_B_W  = 16;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int P_W      = THR_W + MS_W;          // threshold * ms
    localparam int L_W      = TOTAL_W + 10;          // delta * 1000
    localparam int H_W      = P_W + HYST_W;          // threshold * ms * hysteresis
    localparam int ACC_W    = L_W + 8;               // widest compared quantity

    localparam logic [MUL_B_W-1:0] MS_PER_S = MUL_B_W'(1000);

    localparam logic [HYST_W-1:0]   HYST_RESET   = HYST_W'(205);
    localparam logic [MININT_W-1:0] MININT_RESET = MININT_W'(1);

    localparam logic CFG_HYST   = 1'b0;
    localparam logic CFG_MININT = 1'b1;

    localparam logic [KIND_W-1:0] EVT_NONE     = 2'd0;
    localparam logic [KIND_W-1:0] EVT_ANNOUNCE = 2'd1;
    localparam logic [KIND_W-1:0] EVT_WITHDRAW = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DELTA,
        ST_MUL,
        ST_CMP
    } artm_state_t;

endpackage

/* design/app_rate_threshold_monitor_unit.sv */
// ----------------------------------------------------------------------------
// app_rate_threshold_monitor_unit: per-application rate threshold monitor
// Compares each application's byte rate against its threshold with
// hysteresis and reports announce and withdraw events.
// ----------------------------------------------------------------------------
// After reset the block clears each of the 512 entries of its per-application
// store (previous byte totals and triggered flags) and takes no input beat
// during that pass; configuration writes are accepted at any time. An item
// then goes through ST_DELTA for the byte delta and interval floor, then
// ST_MUL, in which a single shared 32 x 16 multiplier forms six partial
// products (threshold times interval, delta times 1000, and that first
// product times the hysteresis factor) into one accumulating adder, and
// last ST_CMP for the final compare and store update. The input is ready
// again in the cycle after the result is loaded. A new item is taken only
// once the previous one has been handed to the output register, so a
// stalled output holds back the input.
module app_rate_threshold_monitor_unit
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [artm_pkg::MININT_W-1:0]   cfg_data,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [artm_pkg::APP_W-1:0]      app_id,
    input  logic [artm_pkg::TOTAL_W-1:0]    byte_total,
    input  logic [artm_pkg::MS_W-1:0]       elapsed_ms,
    input  logic [artm_pkg::THR_W-1:0]      threshold_bps,
    input  logic                            monitored,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [artm_pkg::APP_W-1:0]      app_out,
    output logic [artm_pkg::KIND_W-1:0]     event_kind,
    output logic                            is_triggered
);
    import artm_pkg::*;

    // Store entry: triggered flag above the previous byte total.
    localparam int ENTRY_W = TOTAL_W + 1;

    logic [ENTRY_W-1:0]  mem [NUM_APPS];
    logic [ENTRY_W-1:0]  rd_reg;

    artm_state_t         state_reg, state_next;
    logic [2:0]          step_reg, step_next;
    logic [IDX_W-1:0]    clr_reg, clr_next;

    logic [HYST_W-1:0]   hyst_reg;
    logic [MININT_W-1:0] minint_reg;

    logic [APP_W-1:0]    id_reg;
    logic                id_ok_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [MS_W-1:0]     elapsed_reg;
    logic [THR_W-1:0]    thr_reg;
    logic                mon_reg;

    logic [TOTAL_W-1:0]  delta_reg;
    logic [MS_W-1:0]     ms_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [P_W-1:0]      p_reg;
    logic [L_W-1:0]      l_reg;
    logic [H_W-1:0]      h_reg;

    logic                out_valid_reg;
    logic [APP_W-1:0]    app_out_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic                trig_out_reg;

    logic                in_accept;
    logic                out_free;
    logic                result_load;

    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [PROD_W-1:0]   mul_p;
    logic [ACC_W-1:0]    acc_in;
    logic                acc_hi;
    logic [ACC_W-1:0]    addend;
    logic [ACC_W-1:0]    acc_sum;

    logic [TOTAL_W:0]    diff;
    logic [MININT_W-1:0] floor_ms;
    logic [MS_W-1:0]     floor_ext;

    logic                flag_old;
    logic [ACC_W-1:0]    cmp_lhs;
    logic [ACC_W-1:0]    cmp_rhs;
    logic                cmp_less;
    logic                trig_new;
    logic [KIND_W-1:0]   kind_new;

    assign cfg_ready    = 1'b1;
    assign in_stall     = (state_reg != ST_IDLE);
    assign in_accept    = in_valid && !in_stall;
    assign out_free     = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign app_out      = app_out_reg;
    assign event_kind   = kind_reg;
    assign is_triggered = trig_out_reg;

    // ------------------------------------------------------------------
    // Delta and interval floor
    // ------------------------------------------------------------------
    assign diff      = {1'b0, total_reg} - {1'b0, rd_reg[TOTAL_W-1:0]};
    assign floor_ms  = (minint_reg == '0) ? MININT_W'(1) : minint_reg;
    assign floor_ext = MS_W'(floor_ms);

    // ------------------------------------------------------------------
    // Shared multiplier: operand selection by step
    // ------------------------------------------------------------------
    always_comb
    begin
        case (step_reg)
            3'd0:
            begin
                mul_a = thr_reg[MUL_A_W-1:0];
                mul_b = ms_reg;
            end
            3'd1:
            begin
                mul_a = MUL_A_W'(thr_reg[THR_W-1:MUL_A_W]);
                mul_b = ms_reg;
            end
            3'd2:
            begin
                mul_a = delta_reg[MUL_A_W-1:0];
                mul_b = MS_PER_S;
            end
            3'd3:
            begin
                mul_a = delta_reg[TOTAL_W-1:MUL_A_W];
                mul_b = MS_PER_S;
            end
            3'd4:
            begin
                mul_a = p_reg[MUL_A_W-1:0];
                mul_b = MUL_B_W'(hyst_reg);
            end
            default:
            begin
                mul_a = p_reg[P_W-1:MUL_A_W];
                mul_b = MUL_B_W'(hyst_reg);
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // The product issued in one step is added in the next, so the
    // accumulator chosen here belongs to the previous step.
    always_comb
    begin
        case (step_reg)
            3'd1:
            begin
                acc_in = ACC_W'(p_reg);
                acc_hi = 1'b0;
            end
            3'd2:
            begin
                acc_in = ACC_W'(p_reg);
                acc_hi = 1'b1;
            end
            3'd3:
            begin
                acc_in = ACC_W'(l_reg);
                acc_hi = 1'b0;
            end
            3'd4:
            begin
                acc_in = ACC_W'(l_reg);
                acc_hi = 1'b1;
            end
            3'd5:
            begin
                acc_in = ACC_W'(h_reg);
                acc_hi = 1'b0;
            end
            3'd6:
            begin
                acc_in = ACC_W'(h_reg);
                acc_hi = 1'b1;
            end
            default:
            begin
                acc_in = '0;
                acc_hi = 1'b0;
            end
        endcase
    end

    assign addend  = acc_hi ? ACC_W'({prod_reg, 32'b0}) : ACC_W'(prod_reg);
    assign acc_sum = acc_in + addend;

    // ------------------------------------------------------------------
    // Final compare and event decision
    // ------------------------------------------------------------------
    assign flag_old = rd_reg[TOTAL_W];
    assign cmp_lhs  = flag_old ? {l_reg, 8'b0} : ACC_W'(l_reg);
    assign cmp_rhs  = flag_old ? ACC_W'(h_reg) : ACC_W'(p_reg);
    assign cmp_less = cmp_lhs < cmp_rhs;

    always_comb
    begin
        trig_new = flag_old;
        kind_new = EVT_NONE;
        if (!id_ok_reg)
        begin
            trig_new = 1'b0;
        end
        else if (mon_reg)
        begin
            if (!flag_old && !cmp_less)
            begin
                trig_new = 1'b1;
                kind_new = EVT_ANNOUNCE;
            end
            else if (flag_old && cmp_less)
            begin
                trig_new = 1'b0;
                kind_new = EVT_WITHDRAW;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        clr_next    = clr_reg;
        result_load = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(NUM_APPS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_DELTA;
                end
            end
            ST_DELTA:
            begin
                step_next  = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd6)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (out_free)
                begin
                    result_load = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            step_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            hyst_reg      <= HYST_RESET;
            minint_reg    <= MININT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            clr_reg   <= clr_next;
            if (result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_HYST:   hyst_reg   <= cfg_data[HYST_W-1:0];
                    CFG_MININT: minint_reg <= cfg_data;
                    default:    hyst_reg   <= hyst_reg;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            id_reg      <= app_id;
            id_ok_reg   <= ({1'b0, app_id} < (APP_W + 1)'(NUM_APPS));
            total_reg   <= byte_total;
            elapsed_reg <= elapsed_ms;
            thr_reg     <= threshold_bps;
            mon_reg     <= monitored;
        end

        if (state_reg == ST_DELTA)
        begin
            delta_reg <= diff[TOTAL_W] ? '0 : diff[TOTAL_W-1:0];
            ms_reg    <= (elapsed_reg < floor_ext) ? floor_ext : elapsed_reg;
            p_reg     <= '0;
            l_reg     <= '0;
            h_reg     <= '0;
        end

        if (state_reg == ST_MUL)
        begin
            prod_reg <= mul_p;
            case (step_reg) inside
                3'd1, 3'd2: p_reg <= acc_sum[P_W-1:0];
                3'd3, 3'd4: l_reg <= acc_sum[L_W-1:0];
                3'd5, 3'd6: h_reg <= acc_sum[H_W-1:0];
                default:    p_reg <= p_reg;
            endcase
        end

        if (result_load)
        begin
            app_out_reg  <= id_reg;
            kind_reg     <= kind_new;
            trig_out_reg <= trig_new;
        end
    end

    // ------------------------------------------------------------------
    // Per-application store: clearing pass, item read and write-back
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem[clr_reg] <= '0;
        end
        else if (result_load && id_ok_reg)
        begin
            mem[id_reg[IDX_W-1:0]] <= {trig_new, total_reg};
        end
        if (in_accept)
        begin
            rd_reg <= mem[app_id[IDX_W-1:0]];
        end
    end

endmodule
